FILE: rtl/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder.
// Holds widths, reset constants and the command word passed from front to back.
package u8d_pkg;

  localparam int unsigned CpW          = 21;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned FbCntW       = 3;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned ApbAddrW     = 2;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CpW-1:0]      FallbackReset = 21'h00FFFD;
  localparam logic [ApbAddrW-1:0] AddrFallback  = 2'd0;

  localparam logic [CpW-1:0] SurrLow  = 21'h00D800;
  localparam logic [CpW-1:0] SurrHigh = 21'h00DFFF;

  // One command per byte that causes results: n_fb fallbacks first,
  // then one decoded value if has_val is set.
  typedef struct packed {
    logic [FbCntW-1:0] n_fb;
    logic              has_val;
    logic [CpW-1:0]    val;
  } cmd_t;

endpackage

FILE: rtl/u8d_byte_if.sv
// Byte input channel of the UTF-8 decoder.
// Depends on u8d_pkg for field widths.
interface u8d_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::ByteW-1:0]    in_byte;
  logic                         block_end;

  modport source (output valid, output in_byte, output block_end, input ready);
  modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

FILE: rtl/u8d_cp_if.sv
// Code point output channel of the UTF-8 decoder.
// Depends on u8d_pkg for field widths.
interface u8d_cp_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::CpW-1:0]    code_point;
  logic                       was_invalid;
  logic                       run_last;

  modport source (output valid, output code_point, output was_invalid,
                  output run_last, input ready);
  modport sink   (input valid, input code_point, input was_invalid,
                  input run_last, output ready);
endinterface

FILE: rtl/u8d_front.sv
// Front end: accepts bytes, tracks the pending sequence, emits commands.
// Depends on u8d_pkg and u8d_byte_if.
module u8d_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  u8d_byte_if.sink        byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output u8d_pkg::cmd_t   cmd_o
);

  logic [u8d_pkg::CpW-1:0] partial_q, partial_d;
  logic [1:0]              held_q, held_d;
  logic [1:0]              needed_q, needed_d;

  logic [u8d_pkg::ByteW-1:0] b;
  logic                      accept;
  logic                      cont;
  logic [u8d_pkg::CpW-1:0]   shifted;
  logic [u8d_pkg::FbCntW-1:0] base_fb;

  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.in_byte;
  assign cont         = (b[7:6] == 2'b10);
  assign shifted      = {partial_q[u8d_pkg::CpW-7:0], b[5:0]};

  always_comb begin
    partial_d   = partial_q;
    held_d      = held_q;
    needed_d    = needed_q;
    cmd_o.n_fb  = '0;
    cmd_o.has_val = 1'b0;
    cmd_o.val   = '0;
    base_fb     = '0;

    if (held_q != 2'd0 && cont) begin
      if (held_q >= needed_q) begin
        if (needed_q == 2'd2 && shifted >= u8d_pkg::SurrLow &&
            shifted <= u8d_pkg::SurrHigh) begin
          cmd_o.n_fb = 3'd1;
        end else begin
          cmd_o.has_val = 1'b1;
          cmd_o.val     = shifted;
        end
        partial_d = '0;
        held_d    = '0;
        needed_d  = '0;
      end else if (byte_i.block_end) begin
        // Lead, each held continuation and this byte all fall back.
        cmd_o.n_fb = {1'b0, held_q} + 3'd1;
        partial_d  = '0;
        held_d     = '0;
        needed_d   = '0;
      end else begin
        partial_d = shifted;
        held_d    = held_q + 2'd1;
      end
    end else begin
      // An interrupted sequence flushes what it holds, then the byte starts afresh.
      if (held_q != 2'd0) begin
        base_fb = {1'b0, held_q};
      end
      partial_d = '0;
      held_d    = '0;
      needed_d  = '0;
      cmd_o.n_fb = base_fb;
      if (b[7] == 1'b0) begin
        cmd_o.has_val = 1'b1;
        cmd_o.val     = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, b};
      end else if (b >= 8'hC0 && b <= 8'hF7 && !byte_i.block_end) begin
        held_d = 2'd1;
        if (b < 8'hE0) begin
          partial_d = {16'd0, b[4:0]};
          needed_d  = 2'd1;
        end else if (b < 8'hF0) begin
          partial_d = {17'd0, b[3:0]};
          needed_d  = 2'd2;
        end else begin
          partial_d = {18'd0, b[2:0]};
          needed_d  = 2'd3;
        end
      end else begin
        cmd_o.n_fb = base_fb + 3'd1;
      end
    end
  end

  assign push_o = accept && (cmd_o.n_fb != '0 || cmd_o.has_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      held_q    <= '0;
      needed_q  <= '0;
    end else if (accept) begin
      partial_q <= partial_d;
      held_q    <= held_d;
      needed_q  <= needed_d;
    end
  end

endmodule

FILE: rtl/u8d_queue.sv
// Short command queue between the front and back ends.
// Depends on u8d_pkg for the command type.
module u8d_queue #(
  parameter int unsigned Depth = u8d_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8d_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output u8d_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  u8d_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/u8d_back.sv
// Back end: expands commands into code point words, one per cycle unless cp_o stalls.
// Depends on u8d_pkg and u8d_cp_if.
module u8d_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [u8d_pkg::CpW-1:0] fallback_i,
  input  logic                    q_valid_i,
  input  u8d_pkg::cmd_t           q_cmd_i,
  output logic                    pop_o,
  u8d_cp_if.source                cp_o
);

  logic          act_q, act_d;
  u8d_pkg::cmd_t cur_q, cur_d;
  u8d_pkg::cmd_t cur;
  logic          cur_valid, slot, fire, is_fb, last;

  logic                    ovalid_q, ovalid_d;
  logic [u8d_pkg::CpW-1:0] ocp_q;
  logic                    oinv_q, olast_q;

  // A command still being expanded has priority over the queue head.
  assign cur       = act_q ? cur_q : q_cmd_i;
  assign cur_valid = act_q || q_valid_i;
  assign slot      = !ovalid_q || cp_o.ready;
  assign fire      = slot && cur_valid;
  assign pop_o     = fire && !act_q;
  assign is_fb     = (cur.n_fb != '0);
  assign last      = is_fb ? (cur.n_fb == 3'd1 && !cur.has_val) : 1'b1;

  always_comb begin
    act_d    = act_q;
    cur_d    = cur_q;
    ovalid_d = ovalid_q;
    if (fire) begin
      act_d    = !last;
      cur_d    = cur;
      cur_d.n_fb = is_fb ? cur.n_fb - 3'd1 : '0;
      ovalid_d = 1'b1;
    end else if (cp_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (fire) begin
      ocp_q   <= is_fb ? fallback_i : cur.val;
      oinv_q  <= is_fb;
      olast_q <= last;
    end
  end

  assign cp_o.valid       = ovalid_q;
  assign cp_o.code_point  = ocp_q;
  assign cp_o.was_invalid = oinv_q;
  assign cp_o.run_last    = olast_q;

endmodule

FILE: rtl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder: top level with the APB register and the three stages.
// Depends on u8d_pkg, u8d_byte_if, u8d_cp_if, u8d_front, u8d_queue and u8d_back.
//
// Usage: raw bytes enter on byte_i (valid/ready, in_byte, block_end marks the
// last byte of a block). Decoded code points leave on cp_o, each word carrying
// code_point, was_invalid and run_last (set on the last word a byte causes).
// The fallback code point sits in the only register, at APB byte address 0.
// Throughput is one byte per cycle and one output word per cycle. A byte that
// causes several words (up to four, when a sequence is broken off) holds the
// output until they are all sent, while the front keeps taking bytes until the
// command queue of QueueDepth entries fills. With the queue empty, the command
// of an accepted byte is written into the queue at the accepting edge and then
// moves into the output register, from which its first word shows on cp_o.
// Bytes that only extend a pending sequence produce no word. When cp_o stalls,
// the output register holds its word, the back end stops, and byte_i.ready
// falls once the queue is full.
// Reset clears the pending sequence, empties the queue and output, and sets the
// fallback to U+FFFD.
module utf8_byte_stream_decoder #(
  parameter int unsigned QueueDepth = u8d_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [u8d_pkg::ApbAddrW-1:0]  paddr,
  input  logic [u8d_pkg::ApbDataW-1:0]  pwdata,
  output logic [u8d_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  u8d_byte_if.sink                      byte_i,
  u8d_cp_if.source                      cp_o
);

  logic [u8d_pkg::CpW-1:0] fallback_q;
  logic                    push, full, pop, q_valid;
  u8d_pkg::cmd_t           push_cmd, head_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == u8d_pkg::AddrFallback) ?
                  {{(u8d_pkg::ApbDataW-u8d_pkg::CpW){1'b0}}, fallback_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= u8d_pkg::FallbackReset;
    end else if (psel && penable && pwrite && paddr == u8d_pkg::AddrFallback) begin
      fallback_q <= pwdata[u8d_pkg::CpW-1:0];
    end
  end

  u8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  u8d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fallback_i (fallback_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .pop_o      (pop),
    .cp_o       (cp_o)
  );

endmodule

FILE: tb/sv/utf8_byte_stream_decoder_tb.sv
// Self-checking testbench for utf8_byte_stream_decoder: directed table, then random runs.
// Depends on u8d_pkg, u8d_byte_if, u8d_cp_if and the decoder RTL.
`timescale 1ns / 100ps

module utf8_byte_stream_decoder_tb;
  import u8d_pkg::*;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           bad;
    logic           last;
  } cp_word_t;

  // A byte as it is offered, with a typed-in word where the answer is obvious.
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             e;
    logic             known;
    logic [CpW-1:0]   cp;
    logic             bad;
  } byte_row_t;

  localparam int NumDirRows = 27;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  u8d_byte_if byte_if ();
  u8d_cp_if   cp_if ();

  utf8_byte_stream_decoder i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .byte_i  (byte_if),
    .cp_o    (cp_if)
  );

  // Decoder state mirrored by the predictor.
  logic [CpW-1:0] fallback_cp;
  logic [CpW-1:0] seq_bits;
  logic [1:0]     seq_held;
  logic [1:0]     seq_needed;

  cp_word_t  byte_words[$];
  cp_word_t  expected_cps[$];
  byte_row_t offered_bytes[$];

  int errors;
  int bytes_sent;
  int words_checked;
  int fallback_words;
  int four_word_bytes;
  int steady_left;
  bit hold_req;

  byte_row_t dir_rows [NumDirRows] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
    '{8'h80, 1'b0, 1'b1, FallbackReset, 1'b1},
    '{8'hBF, 1'b1, 1'b1, FallbackReset, 1'b1},
    '{8'hF8, 1'b0, 1'b1, FallbackReset, 1'b1},
    '{8'hFF, 1'b1, 1'b1, FallbackReset, 1'b1},
    '{8'hC3, 1'b1, 1'b1, FallbackReset, 1'b1},
    '{8'hE2, 1'b0, 1'b0, '0, 1'b0},
    '{8'h82, 1'b0, 1'b0, '0, 1'b0},
    '{8'hAC, 1'b0, 1'b0, '0, 1'b0},
    '{8'hED, 1'b0, 1'b0, '0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, '0, 1'b0},
    '{8'h80, 1'b0, 1'b1, FallbackReset, 1'b1},
    '{8'hF7, 1'b0, 1'b0, '0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, '0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, '0, 1'b0},
    '{8'hBF, 1'b1, 1'b1, 21'h1FFFFF, 1'b0},
    '{8'hF0, 1'b0, 1'b0, '0, 1'b0},
    '{8'h90, 1'b0, 1'b0, '0, 1'b0},
    '{8'h80, 1'b0, 1'b0, '0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, '0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, '0, 1'b0},
    '{8'h82, 1'b1, 1'b0, '0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, '0, 1'b0},
    '{8'h41, 1'b0, 1'b0, '0, 1'b0},
    '{8'hC0, 1'b0, 1'b0, '0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 21'h000000, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("utf8_byte_stream_decoder test failed");
    $finish;
  end

  function automatic void push_word(input logic [CpW-1:0] cp, input logic bad);
    cp_word_t w;
    w.cp   = cp;
    w.bad  = bad;
    w.last = 1'b0;
    byte_words.insert(byte_words.size(), w);
  endfunction

  function automatic void clear_seq();
    seq_bits   = '0;
    seq_held   = '0;
    seq_needed = '0;
  endfunction

  // Works out the words one byte causes and advances the mirrored state.
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic e);
    byte_words.delete();
    if (seq_held != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_bits = {seq_bits[CpW-7:0], b[5:0]};
        if (seq_held >= seq_needed) begin
          if (seq_needed == 2'd2 && seq_bits >= SurrLow && seq_bits <= SurrHigh) begin
            push_word(fallback_cp, 1'b1);
          end else begin
            push_word(seq_bits, 1'b0);
          end
          clear_seq();
        end else if (e) begin
          repeat (int'(seq_held) + 1) push_word(fallback_cp, 1'b1);
          clear_seq();
        end else begin
          seq_held = seq_held + 2'd1;
        end
        if (byte_words.size() > 0) byte_words[byte_words.size()-1].last = 1'b1;
        return;
      end
      // A sequence broken off: fallbacks first, then the byte starts over.
      repeat (int'(seq_held)) push_word(fallback_cp, 1'b1);
      clear_seq();
    end
    if (b < 8'h80) begin
      push_word({{(CpW-ByteW){1'b0}}, b}, 1'b0);
    end else if (b >= 8'hC0 && b <= 8'hF7) begin
      if (e) begin
        push_word(fallback_cp, 1'b1);
      end else if (b < 8'hE0) begin
        seq_bits   = {16'b0, b[4:0]};
        seq_held   = 2'd1;
        seq_needed = 2'd1;
      end else if (b < 8'hF0) begin
        seq_bits   = {17'b0, b[3:0]};
        seq_held   = 2'd1;
        seq_needed = 2'd2;
      end else begin
        seq_bits   = {18'b0, b[2:0]};
        seq_held   = 2'd1;
        seq_needed = 2'd3;
      end
    end else begin
      push_word(fallback_cp, 1'b1);
    end
    if (byte_words.size() > 0) byte_words[byte_words.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    byte_row_t row;
    cp_word_t  want;
    cp_word_t  typed;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        row = offered_bytes.pop_front();
        decode_byte(row.b, row.e);
        if (byte_words.size() == 4) four_word_bytes++;
        if (row.known) begin
          typed.cp   = row.cp;
          typed.bad  = row.bad;
          typed.last = 1'b1;
          expected_cps.insert(expected_cps.size(), typed);
        end else begin
          foreach (byte_words[k]) expected_cps.insert(expected_cps.size(), byte_words[k]);
        end
      end
      if (cp_if.valid && cp_if.ready) begin
        words_checked++;
        if (cp_if.was_invalid) fallback_words++;
        if (expected_cps.size() == 0) begin
          $error("unexpected word: code_point %06h", cp_if.code_point);
          errors++;
        end else begin
          want = expected_cps.pop_front();
          if (cp_if.code_point !== want.cp) begin
            $error("code_point: expected %06h, got %06h", want.cp, cp_if.code_point);
            errors++;
          end
          if (cp_if.was_invalid !== want.bad) begin
            $error("was_invalid: expected %0b, got %0b", want.bad, cp_if.was_invalid);
            errors++;
          end
          if (cp_if.run_last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, cp_if.run_last);
            errors++;
          end
        end
      end
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // The receiver: bursts of ready, random gaps, and one long hold on request.
  initial begin
    int unsigned burst;
    int unsigned gap;
    cp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        cp_if.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
        cp_if.ready <= 1'b1;
        repeat (burst) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          cp_if.ready <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_row(input byte_row_t row);
    int unsigned gap;
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) steady_left = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_bytes.insert(offered_bytes.size(), row);
    byte_if.valid     <= 1'b1;
    byte_if.in_byte   <= row.b;
    byte_if.block_end <= row.e;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic e);
    byte_row_t row;
    row       = '0;
    row.b     = b;
    row.e     = e;
    send_row(row);
  endtask

  // Sends the first keep bytes of a len-byte encoding of a random code point.
  task automatic send_char(input int unsigned len, input int unsigned keep,
                           input logic end_last, input logic surrogate);
    logic [CpW-1:0]   cp;
    logic [ByteW-1:0] enc [4];
    cp = CpW'($urandom);
    case (len)
      1: begin
        enc[0] = {1'b0, cp[6:0]};
      end
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        if (surrogate) cp[15:11] = 5'b11011;
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(enc[i], (i == keep - 1) ? end_last : 1'b0);
  endtask

  task automatic random_run(input int n);
    int          stop_at;
    int unsigned r;
    int unsigned len;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r   = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (r < 72) begin
        send_char(len, len, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      end else if (r < 86) begin
        // Truncated sequence: either the block ends early or the next byte interrupts.
        if (len == 1) len = 2;
        send_char(len, $urandom_range(1, len - 1), $urandom_range(0, 2) == 0, 1'b0);
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
    // Close the block so no sequence is left pending across a register write.
    send_byte(8'h0A, 1'b1);
  endtask

  // Waits on the clock first, so the monitor has logged the last accepted byte.
  task automatic drain();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_fallback_reg(input logic [CpW-1:0] value);
    logic [ApbDataW-1:0] rdata;
    apb_access(1'b0, AddrFallback, '0, rdata);
    if (rdata !== ApbDataW'(value)) begin
      $error("fallback_code: expected %06h, got %08h", value, rdata);
      errors++;
    end
  endtask

  task automatic write_fallback(input logic [CpW-1:0] value);
    logic [ApbDataW-1:0] rdata;
    apb_access(1'b1, AddrFallback, ApbDataW'(value), rdata);
    fallback_cp = value;
    check_fallback_reg(value);
  endtask

  initial begin
    errors          = 0;
    bytes_sent      = 0;
    words_checked   = 0;
    fallback_words  = 0;
    four_word_bytes = 0;
    steady_left     = 0;
    hold_req        = 1'b0;
    fallback_cp     = FallbackReset;
    clear_seq();
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    byte_if.valid     = 1'b0;
    byte_if.in_byte   = '0;
    byte_if.block_end = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_fallback_reg(FallbackReset);
    for (int i = 0; i < NumDirRows; i++) send_row(dir_rows[i]);
    random_run(110);
    drain();

    // Top of the range, with the receiver held off while bytes keep coming.
    write_fallback(21'h10FFFF);
    hold_req    = 1'b1;
    steady_left = 40;
    random_run(110);
    drain();

    write_fallback(21'h000000);
    random_run(110);
    drain();

    write_fallback(CpW'($urandom_range(0, 21'h10FFFF)));
    random_run(110);
    drain();

    if (expected_cps.size() != 0) begin
      $error("%0d expected words never arrived", expected_cps.size());
      errors++;
    end
    $display("Sent %0d bytes over four fallback settings, %0d words checked,",
             bytes_sent, words_checked);
    $display("%0d of them fallbacks, %0d bytes causing four words.",
             fallback_words, four_word_bytes);
    if (errors == 0) begin
      $display("utf8_byte_stream_decoder test passed");
    end else begin
      $display("utf8_byte_stream_decoder test failed");
    end
    $finish;
  end

endmodule
